// ===== src/lrh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrh_pkg
// Shared types and fixed widths for the histogram largest-rectangle block.
// ----------------------------------------------------------------------------
package lrh_pkg;

  localparam int HEIGHT_W   = 32;
  localparam int OUT_AREA_W = 42;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_POPRD,
    ST_SCORE,
    ST_DRAIN
  } lrh_state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } lrh_stk_cmd_t;

  typedef struct packed {
    logic mul;
    logic cmp;
    logic clr;
  } lrh_area_cmd_t;

endpackage

// ===== src/lrh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrh_if
// Valid/ready channels for bar items and area result items.
// ----------------------------------------------------------------------------
interface lrh_bar_if import lrh_pkg::*;;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] bar_height;
  logic                is_last;

  modport source (output valid, output bar_height, output is_last, input ready);
  modport sink   (input valid, input bar_height, input is_last, output ready);
endinterface

interface lrh_area_if import lrh_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OUT_AREA_W-1:0] rect_area;
  logic                  overflow;

  modport source (output valid, output rect_area, output overflow, input ready);
  modport sink   (input valid, input rect_area, input overflow, output ready);
endinterface

// ===== src/lrh_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrh_stack
// Monotonic bar stack: top entry in registers, the rest in a memory with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module lrh_stack import lrh_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10,
  parameter int CNT_W = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrh_stk_cmd_t        cmd_i,
  input  logic [HEIGHT_W-1:0] push_h_i,
  input  logic [IDX_W-1:0]    push_idx_i,
  output logic [CNT_W-1:0]    depth_o,
  output logic [HEIGHT_W-1:0] top_h_o,
  output logic [IDX_W-1:0]    below_idx_o
);

  localparam int ENTRY_W = HEIGHT_W + IDX_W;

  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rd_q;
  logic [CNT_W-1:0]    depth_q;
  logic                refill_q;
  logic [HEIGHT_W-1:0] top_h_q;
  logic [IDX_W-1:0]    top_idx_q;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic                rd_en;

  // memory holds entries below the top; the top itself lives in registers
  assign wr_addr = IDX_W'(depth_q - CNT_W'(1));
  assign rd_addr = IDX_W'(depth_q - CNT_W'(2));
  assign wr_en   = cmd_i.push && (depth_q != '0);
  assign rd_en   = cmd_i.pop && (depth_q > CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {top_h_q, top_idx_q};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      refill_q <= 1'b0;
    end else begin
      refill_q <= cmd_i.pop;
      if (cmd_i.push) begin
        depth_q <= depth_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        depth_q <= depth_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      top_h_q   <= push_h_i;
      top_idx_q <= push_idx_i;
    end else if (refill_q && (depth_q != '0)) begin
      top_h_q   <= rd_q[ENTRY_W-1:IDX_W];
      top_idx_q <= rd_q[IDX_W-1:0];
    end
  end

  assign depth_o     = depth_q;
  assign top_h_o     = top_h_q;
  assign below_idx_o = rd_q[IDX_W-1:0];

endmodule

// ===== src/lrh_area.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrh_area
// Shared area unit: one registered multiply, then a compare into best area.
// ----------------------------------------------------------------------------
module lrh_area import lrh_pkg::*; #(
  parameter int CNT_W  = 11,
  parameter int AREA_W = 43
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrh_area_cmd_t       cmd_i,
  input  logic [HEIGHT_W-1:0] height_i,
  input  logic [CNT_W-1:0]    width_i,
  output logic [AREA_W-1:0]   best_o
);

  logic [AREA_W-1:0] prod_d;
  logic [AREA_W-1:0] prod_q;
  logic [AREA_W-1:0] best_q;

  assign prod_d = AREA_W'(height_i) * AREA_W'(width_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else if (cmd_i.clr) begin
      best_q <= '0;
    end else if (cmd_i.cmp && (prod_q > best_q)) begin
      best_q <= prod_q;
    end
  end

  assign best_o = best_q;

endmodule

// ===== src/largest_rectangle_in_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_rectangle_in_histogram
// Streams bar heights through a monotonic stack and emits the largest
// rectangle area of each histogram.
// ----------------------------------------------------------------------------
//  channel  dir  payload                      item
//  bar_i    in   bar_height[31:0], is_last    one histogram bar
//  area_o   out  rect_area[41:0], overflow    one per histogram
//
//  a bar is compared with the stack top and pops each taller stacked bar
//  through a memory read, a multiply and a compare in the single area
//  unit; the last bar then pops every bar left on the stack the same way;
//  a bar past capacity is not stacked and only sets the overflow flag
//  reset clears control state only; the stack memory needs no clearing pass
//  a waiting result does not block the next bar; only the final drain step
//  stalls until the output register is free
// ----------------------------------------------------------------------------
module largest_rectangle_in_histogram import lrh_pkg::*; #(
  parameter int MAX_BARS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrh_bar_if.sink    bar_i,
  lrh_area_if.source area_o
);

  localparam int IDX_W  = $clog2(MAX_BARS);
  localparam int CNT_W  = $clog2(MAX_BARS + 1);
  localparam int AREA_W = HEIGHT_W + CNT_W;
  localparam int EXT_W  = (AREA_W > OUT_AREA_W) ? AREA_W : OUT_AREA_W;

  lrh_state_e state_q, state_d;

  logic [HEIGHT_W-1:0]   h_q;
  logic                  last_q;
  logic [CNT_W-1:0]      bar_cnt_q;
  logic                  ovf_q;
  logic                  drain_q;
  logic                  out_valid_q;
  logic [OUT_AREA_W-1:0] out_area_q;
  logic                  out_ovf_q;

  lrh_stk_cmd_t        stk_cmd;
  lrh_area_cmd_t       area_cmd;
  logic [CNT_W-1:0]    depth;
  logic [HEIGHT_W-1:0] top_h;
  logic [IDX_W-1:0]    below_idx;
  logic [CNT_W-1:0]    width;
  logic [AREA_W-1:0]   best;
  logic [EXT_W-1:0]    best_ext;

  logic accept;
  logic full;
  logic pop_cmp;
  logic out_free;
  logic finish;

  assign accept   = bar_i.valid && bar_i.ready;
  assign full     = (bar_cnt_q == CNT_W'(MAX_BARS));
  assign pop_cmp  = (depth != '0) && (top_h > h_q);
  assign out_free = !out_valid_q || area_o.ready;
  assign finish   = (state_q == ST_DRAIN) && (depth == '0) && out_free;

  // width of the popped bar against the current right edge
  assign width = (depth == '0) ? bar_cnt_q
               : CNT_W'(bar_cnt_q - CNT_W'(1) - CNT_W'(below_idx));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            state_d = bar_i.is_last ? ST_DRAIN : ST_IDLE;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (pop_cmp) begin
          state_d = ST_POPRD;
        end else begin
          state_d = last_q ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_POPRD: state_d = ST_SCORE;
      ST_SCORE: state_d = drain_q ? ST_DRAIN : ST_CMP;
      ST_DRAIN: begin
        if (depth != '0) begin
          state_d = ST_POPRD;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    stk_cmd.push = (state_q == ST_CMP) && !pop_cmp;
    stk_cmd.pop  = ((state_q == ST_CMP) && pop_cmp)
                || ((state_q == ST_DRAIN) && (depth != '0));
    area_cmd.mul = (state_q == ST_POPRD);
    area_cmd.cmp = (state_q == ST_SCORE);
    area_cmd.clr = finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drain_q     <= 1'b0;
      bar_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d == ST_DRAIN) begin
        drain_q <= 1'b1;
      end else if (state_d == ST_IDLE) begin
        drain_q <= 1'b0;
      end
      if (finish) begin
        bar_cnt_q <= '0;
        ovf_q     <= 1'b0;
      end else begin
        if (stk_cmd.push) begin
          bar_cnt_q <= bar_cnt_q + CNT_W'(1);
        end
        if (accept && full) begin
          ovf_q <= 1'b1;
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (area_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign best_ext = EXT_W'(best);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_q    <= bar_i.bar_height;
      last_q <= bar_i.is_last;
    end
    if (finish) begin
      out_area_q <= best_ext[OUT_AREA_W-1:0];
      out_ovf_q  <= ovf_q;
    end
  end

  lrh_stack #(
    .DEPTH (MAX_BARS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stk_cmd),
    .push_h_i    (h_q),
    .push_idx_i  (bar_cnt_q[IDX_W-1:0]),
    .depth_o     (depth),
    .top_h_o     (top_h),
    .below_idx_o (below_idx)
  );

  lrh_area #(
    .CNT_W  (CNT_W),
    .AREA_W (AREA_W)
  ) u_area (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (area_cmd),
    .height_i (top_h),
    .width_i  (width),
    .best_o   (best)
  );

  assign bar_i.ready      = (state_q == ST_IDLE);
  assign area_o.valid     = out_valid_q;
  assign area_o.rect_area = out_area_q;
  assign area_o.overflow  = out_ovf_q;

endmodule

// ===== src/lrh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrh_checker
// Port-level checks on the bar and area channels of the top level.
// ----------------------------------------------------------------------------
module lrh_checker import lrh_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_last_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [OUT_AREA_W-1:0] out_area_i,
  input logic                  out_ovf_i
);

  // a result item waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_area_i) && $stable(out_ovf_i))
    else $error("result payload changed while stalled");

  // the last bar always needs the drain step, so the input closes
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input still open after last bar");

  // a result comes out of the drain, never while the input is open
  a_out_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a drain");

endmodule

bind largest_rectangle_in_histogram lrh_checker u_lrh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (bar_i.valid),
  .in_ready_i  (bar_i.ready),
  .in_last_i   (bar_i.is_last),
  .out_valid_i (area_o.valid),
  .out_ready_i (area_o.ready),
  .out_area_i  (area_o.rect_area),
  .out_ovf_i   (area_o.overflow)
);

// ===== tb/lrh_area_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrh_area_checker
// Watches the bar and area channels, runs its own monotonic-stack model of
// every accepted bar and compares each area item with the oldest expected one.
// ----------------------------------------------------------------------------
module lrh_area_checker import lrh_pkg::*; #(
  parameter int MAX_BARS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrh_bar_if          bar_mon,
  lrh_area_if         area_mon,
  output int unsigned areas_owed_o,
  output int unsigned mismatches_o
);

  typedef struct packed {
    logic [OUT_AREA_W-1:0] area;
    logic                  overflow;
  } area_result_t;

  area_result_t        pending_areas[$];
  logic [HEIGHT_W-1:0] stk_height [MAX_BARS];
  int unsigned         stk_index  [MAX_BARS];
  int unsigned         stk_depth;
  int unsigned         bars_kept;
  logic [63:0]         best_area;
  logic                too_many;
  int unsigned         mismatches;

  // pop the top bar and score it against the given right edge
  function automatic void score_top(input int unsigned right_edge);
    int unsigned d;
    logic [63:0] width;
    logic [63:0] area;
    d         = stk_depth - 1;
    stk_depth = d;
    if (d == 0) begin
      width = right_edge;
    end else begin
      width = right_edge - 1 - stk_index[d-1];
    end
    area = {32'd0, stk_height[d]} * width;
    if (area > best_area) begin
      best_area = area;
    end
  endfunction

  function automatic void absorb_bar(input logic [HEIGHT_W-1:0] h, input logic last);
    area_result_t done;
    if (bars_kept >= MAX_BARS) begin
      // bar beyond capacity: only flagged, but is_last still closes the histogram
      too_many = 1'b1;
    end else begin
      while (stk_depth > 0 && stk_height[stk_depth-1] > h) begin
        score_top(bars_kept);
      end
      if (stk_depth < MAX_BARS) begin
        stk_height[stk_depth] = h;
        stk_index[stk_depth]  = bars_kept;
        stk_depth++;
      end
      bars_kept++;
    end
    if (last) begin
      while (stk_depth > 0) begin
        score_top(bars_kept);
      end
      done.area     = best_area[OUT_AREA_W-1:0];
      done.overflow = too_many;
      pending_areas.push_back(done);
      stk_depth = 0;
      bars_kept = 0;
      best_area = '0;
      too_many  = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    area_result_t want;
    if (!rst_ni) begin
      pending_areas.delete();
      stk_depth  = 0;
      bars_kept  = 0;
      best_area  = '0;
      too_many   = 1'b0;
      mismatches = 0;
    end else begin
      if (area_mon.valid && area_mon.ready) begin
        if (pending_areas.size() == 0) begin
          $display("%t unexpected area item: rect_area %0d overflow %0b", $time,
                   area_mon.rect_area, area_mon.overflow);
          mismatches++;
        end else begin
          want = pending_areas.pop_front();
          if (area_mon.rect_area !== want.area) begin
            $display("%t rect_area mismatch: expected %0d actual %0d", $time,
                     want.area, area_mon.rect_area);
            mismatches++;
          end
          if (area_mon.overflow !== want.overflow) begin
            $display("%t overflow mismatch: expected %0b actual %0b", $time,
                     want.overflow, area_mon.overflow);
            mismatches++;
          end
        end
      end
      // a result never leaves in the same cycle as its own last bar
      if (bar_mon.valid && bar_mon.ready) begin
        absorb_bar(bar_mon.bar_height, bar_mon.is_last);
      end
    end
    areas_owed_o <= pending_areas.size();
    mismatches_o <= mismatches;
  end

endmodule

// ===== tb/largest_rectangle_in_histogram_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_rectangle_in_histogram_tb
// Feeds directed and random histograms, including one past the bar capacity,
// with random gaps and stalls plus a long output hold-off; lrh_area_checker
// predicts and compares every area item.
// ----------------------------------------------------------------------------
module largest_rectangle_in_histogram_tb;
  import lrh_pkg::*;

  localparam int MAX_BARS     = 1024;
  localparam int TARGET_BARS  = 1900;
  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 64;

  typedef enum int {
    MIX_TINY,
    MIX_FULL,
    MIX_TALL,
    MIX_MID
  } height_mix_e;

  logic        clk_i;
  logic        rst_ni;
  logic        calm;
  logic        hold_req;
  int unsigned bars_sent;
  int unsigned areas_owed;
  int unsigned mismatches;

  lrh_bar_if  bar_ch ();
  lrh_area_if area_ch ();

  largest_rectangle_in_histogram #(
    .MAX_BARS(MAX_BARS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .bar_i (bar_ch),
    .area_o(area_ch)
  );

  lrh_area_checker #(
    .MAX_BARS(MAX_BARS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bar_mon     (bar_ch),
    .area_mon    (area_ch),
    .areas_owed_o(areas_owed),
    .mismatches_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls, one long hold-off when asked
  initial begin
    int unsigned hold_left;
    logic        hold_taken;
    hold_left     = 0;
    hold_taken    = 1'b0;
    area_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        area_ch.ready <= 1'b0;
      end else begin
        area_ch.ready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  // ends the run when nothing moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((bar_ch.valid && bar_ch.ready) || (area_ch.valid && area_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("largest_rectangle_in_histogram_tb NOT OK");
    $finish;
  end

  function automatic logic [HEIGHT_W-1:0] pick_height(input height_mix_e mix);
    case (mix)
      MIX_TINY: pick_height = $urandom_range(7);
      MIX_FULL: pick_height = $urandom();
      MIX_TALL: pick_height = 32'hFFFF_FFFF - $urandom_range(15);
      default:  pick_height = $urandom_range(1000);
    endcase
  endfunction

  // enters and leaves at a falling edge
  task automatic send_bar(input logic [HEIGHT_W-1:0] h, input logic last);
    while (!calm && $urandom_range(99) < 26) begin
      bar_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    bar_ch.valid      <= 1'b1;
    bar_ch.bar_height <= h;
    bar_ch.is_last    <= last;
    @(posedge clk_i);
    while (!bar_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    bars_sent++;
  endtask

  task automatic send_seq(input logic [HEIGHT_W-1:0] hs [$]);
    foreach (hs[i]) send_bar(hs[i], i == hs.size() - 1);
  endtask

  task automatic send_hist(input int unsigned len, input height_mix_e mix);
    for (int unsigned i = 0; i < len; i++) begin
      send_bar(pick_height(mix), i == len - 1);
    end
  endtask

  initial begin
    int unsigned len;
    height_mix_e mix;
    calm              = 1'b0;
    hold_req          = 1'b0;
    bars_sent         = 0;
    bar_ch.valid      = 1'b0;
    bar_ch.bar_height = '0;
    bar_ch.is_last    = 1'b0;
    rst_ni            = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single bars, equal heights, zeros, rising, falling, classic shape
    send_seq('{32'd0});
    send_seq('{32'hFFFF_FFFF});
    send_seq('{32'd3, 32'd3, 32'd3});
    send_seq('{32'd5, 32'd0, 32'd5});
    send_seq('{32'd2, 32'd1, 32'd5, 32'd6, 32'd2, 32'd3});
    send_seq('{32'd1, 32'd2, 32'd3, 32'd4});
    send_seq('{32'd4, 32'd3, 32'd2, 32'd1});
    send_seq('{32'hFFFF_FFFF, 32'hFFFF_FFFF});

    // full stack of tallest bars, then one ignored bar that carries is_last
    calm = 1'b1;
    for (int unsigned i = 0; i < MAX_BARS; i++) begin
      send_bar(32'hFFFF_FFFF, 1'b0);
    end
    send_bar(pick_height(MIX_FULL), 1'b1);

    // output held off while short histograms keep coming
    hold_req = 1'b1;
    for (int unsigned i = 0; i < 20; i++) begin
      send_hist($urandom_range(1, 3), height_mix_e'($urandom_range(3)));
    end
    calm = 1'b0;

    while (bars_sent < TARGET_BARS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      mix = height_mix_e'($urandom_range(3));
      send_hist(len, mix);
    end
    bar_ch.valid <= 1'b0;

    while (areas_owed != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && areas_owed == 0) begin
      $display("largest_rectangle_in_histogram_tb OK");
    end else begin
      $display("largest_rectangle_in_histogram_tb NOT OK");
    end
    $finish;
  end

endmodule
